/* src/htlcd_pkg.sv */
package htlcd_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_TIMER_ENABLE      = 3'd0;
   localparam logic [2:0] CSR_TIMER_RATE_SELECT = 3'd1;
   localparam logic [2:0] CSR_TIMER_RELOAD      = 3'd2;
   localparam logic [2:0] CSR_LINE_COMPARE      = 3'd3;
   localparam logic [2:0] CSR_STAT_IRQ_ENABLES  = 3'd4;
   localparam logic [2:0] CSR_LCD_ENABLE        = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // stat modes
   localparam logic [1:0] MODE_HBLANK   = 2'd0;
   localparam logic [1:0] MODE_VBLANK   = 2'd1;
   localparam logic [1:0] MODE_OAM      = 2'd2;
   localparam logic [1:0] MODE_TRANSFER = 2'd3;

   // stat interrupt enable bit positions
   localparam int IRQ_EN_HBLANK = 0;
   localparam int IRQ_EN_VBLANK = 1;
   localparam int IRQ_EN_OAM    = 2;
   localparam int IRQ_EN_COINC  = 3;

   // timing constants
   localparam int          DIV_SHIFT   = 6;    // log2 of the divider period
   localparam logic [8:0]  LINE_PERIOD = 9'd114;
   localparam logic [8:0]  OAM_START   = 9'd51;
   localparam logic [8:0]  XFER_START  = 9'd71;
   localparam logic [7:0]  LAST_LINE   = 8'd153;
   localparam logic [7:0]  VBLANK_LINE = 8'd144;

   typedef struct packed {
      logic       timer_enable;
      logic [1:0] timer_rate_select;
      logic [7:0] timer_reload;
      logic [7:0] line_compare;
      logic [3:0] stat_irq_enables;
      logic       lcd_enable;
   } cfg_type;

   // one classified step waiting for the back end
   typedef struct packed {
      logic [7:0] cycles;
      logic       lcd_on;
      logic       timer_on;
      logic [3:0] rate_shift;
   } item_type;

   // log2 of the timer period for a rate select code
   function automatic logic [3:0] rate_shift(input logic [1:0] sel);
      logic [3:0] s;
      case (sel)
         2'd0:    s = 4'd8;
         2'd1:    s = 4'd2;
         2'd2:    s = 4'd4;
         2'd3:    s = 4'd6;
         default: s = 4'd8;
      endcase
      return s;
   endfunction

endpackage

/* src/htlcd_front.sv */
module htlcd_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  htlcd_pkg::cfg_type  cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_cycles,
   output logic                q_valid,
   output htlcd_pkg::item_type q_item,
   input  logic                q_pop
);
   import htlcd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type         q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   item_type         item_in;
   logic             push;

   assign req_ready = (count_ff != FULL_CNT);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_ff[rd_ptr_ff];

   // classify the step against the current configuration
   always_comb begin
      item_in.cycles     = req_cycles;
      item_in.lcd_on     = cfg.lcd_enable;
      item_in.timer_on   = cfg.timer_enable;
      item_in.rate_shift = rate_shift(cfg.timer_rate_select);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

/* src/htlcd_back.sv */
module htlcd_back (
   input  logic                clock,
   input  logic                reset,
   input  htlcd_pkg::cfg_type  cfg,
   input  logic                q_valid,
   input  htlcd_pkg::item_type q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_divider,
   output logic [7:0]          rsp_timer_count,
   output logic [7:0]          rsp_line,
   output logic [1:0]          rsp_lcd_mode,
   output logic                rsp_coincidence,
   output logic                rsp_vblank_irq,
   output logic                rsp_stat_irq,
   output logic                rsp_timer_irq,
   output logic                rsp_draw_request,
   output logic [7:0]          rsp_draw_line_number,
   output logic                rsp_line_end
);
   import htlcd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_BUSY = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type  state_ff, state_in;

   logic [5:0] div_ph_ff, div_ph_in;
   logic [7:0] div_val_ff, div_val_in;
   logic [8:0] line_ph_ff, line_ph_in;
   logic [7:0] line_ff, line_in;
   logic [1:0] mode_ff, mode_in;
   logic       coin_ff, coin_in;
   logic       drawn_ff, drawn_in;
   logic [7:0] tim_ph_ff, tim_ph_in;
   logic [7:0] tim_val_ff, tim_val_in;
   logic [6:0] tick_ff, tick_in;
   logic       lcd_on_ff, lcd_on_in;

   logic       vblank_ff, vblank_in;
   logic       coin_irq_ff, coin_irq_in;
   logic       tirq_ff, tirq_in;
   logic       draw_ff, draw_in;
   logic [7:0] draw_line_ff, draw_line_in;
   logic       hblank_ff, hblank_in;

   logic [8:0] div_sum, line_sum, tim_sum, tick_all, tim_mask, tv_sum;
   logic [7:0] line_next;
   logic       line_pend, tim_pend, finish, stat_mode;

   assign q_pop     = q_valid && ((state_ff == ST_IDLE) || ((state_ff == ST_HOLD) && rsp_ready));
   assign rsp_valid = (state_ff == ST_HOLD);
   assign line_pend = (line_ph_ff >= LINE_PERIOD);
   assign tim_pend  = (tick_ff != '0);
   assign finish    = (state_ff == ST_BUSY) && !line_pend && !tim_pend;

   assign div_sum   = {3'b000, div_ph_ff} + {1'b0, q_item.cycles};
   assign line_sum  = line_ph_ff + {1'b0, q_item.cycles};
   assign tim_sum   = {1'b0, tim_ph_ff} + {1'b0, q_item.cycles};
   assign tick_all  = tim_sum >> q_item.rate_shift;
   assign tim_mask  = (9'd1 << q_item.rate_shift) - 9'd1;
   assign tv_sum    = {1'b0, tim_val_ff} + {2'b00, tick_ff};
   assign line_next = (line_ff >= LAST_LINE) ? 8'd0 : line_ff + 8'd1;

   // mode and hblank stat sources, sampled after all line ends
   assign stat_mode = lcd_on_ff &&
                      ((cfg.stat_irq_enables[IRQ_EN_OAM]    && (mode_ff == MODE_OAM))    ||
                       (cfg.stat_irq_enables[IRQ_EN_VBLANK] && (mode_ff == MODE_VBLANK)) ||
                       (cfg.stat_irq_enables[IRQ_EN_HBLANK] && hblank_ff));

   always_comb begin
      state_in     = state_ff;
      div_ph_in    = div_ph_ff;
      div_val_in   = div_val_ff;
      line_ph_in   = line_ph_ff;
      line_in      = line_ff;
      mode_in      = mode_ff;
      coin_in      = coin_ff;
      drawn_in     = drawn_ff;
      tim_ph_in    = tim_ph_ff;
      tim_val_in   = tim_val_ff;
      tick_in      = tick_ff;
      lcd_on_in    = lcd_on_ff;
      vblank_in    = vblank_ff;
      coin_irq_in  = coin_irq_ff;
      tirq_in      = tirq_ff;
      draw_in      = draw_ff;
      draw_line_in = draw_line_ff;
      hblank_in    = hblank_ff;

      case (state_ff)
         ST_IDLE, ST_HOLD: begin
            if (state_ff == ST_HOLD && rsp_ready) begin
               state_in = ST_IDLE;
            end
            if (q_pop) begin
               state_in     = ST_BUSY;
               lcd_on_in    = q_item.lcd_on;
               vblank_in    = 1'b0;
               coin_irq_in  = 1'b0;
               tirq_in      = 1'b0;
               draw_in      = 1'b0;
               draw_line_in = 8'd0;
               hblank_in    = 1'b0;
               div_ph_in    = div_sum[5:0];
               div_val_in   = div_val_ff + {5'b00000, div_sum[8:DIV_SHIFT]};
               if (q_item.lcd_on) begin
                  line_ph_in = line_sum;
                  if (line_ff >= VBLANK_LINE) begin
                     mode_in = MODE_VBLANK;
                  end else if (line_sum < OAM_START) begin
                     mode_in  = MODE_HBLANK;
                     drawn_in = 1'b0;
                  end else if (line_sum < XFER_START) begin
                     mode_in = MODE_OAM;
                  end else begin
                     mode_in = MODE_TRANSFER;
                     if (!drawn_ff) begin
                        draw_in      = 1'b1;
                        draw_line_in = line_ff;
                        drawn_in     = 1'b1;
                     end
                  end
               end
               if (q_item.timer_on) begin
                  tim_ph_in = tim_sum[7:0] & tim_mask[7:0];
                  tick_in   = tick_all[6:0];
               end else begin
                  tick_in = '0;
               end
            end
         end
         ST_BUSY: begin
            // one line end per cycle
            if (line_pend) begin
               line_ph_in = line_ph_ff - LINE_PERIOD;
               hblank_in  = 1'b1;
               line_in    = line_next;
               if (line_next == VBLANK_LINE) begin
                  mode_in   = MODE_VBLANK;
                  vblank_in = 1'b1;
               end
               coin_in = (cfg.line_compare == line_next);
               if ((cfg.line_compare == line_next) && cfg.stat_irq_enables[IRQ_EN_COINC]) begin
                  coin_irq_in = 1'b1;
               end
            end
            // one timer overflow, or the final partial add, per cycle
            if (tim_pend) begin
               if (tv_sum[8]) begin
                  tim_val_in = cfg.timer_reload;
                  tick_in    = tv_sum[6:0];
                  tirq_in    = 1'b1;
               end else begin
                  tim_val_in = tv_sum[7:0];
                  tick_in    = '0;
               end
            end
            if (finish) begin
               state_in = ST_HOLD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_ph_ff    <= '0;
         div_val_ff   <= '0;
         line_ph_ff   <= '0;
         line_ff      <= '0;
         mode_ff      <= '0;
         coin_ff      <= 1'b0;
         drawn_ff     <= 1'b0;
         tim_ph_ff    <= '0;
         tim_val_ff   <= '0;
         tick_ff      <= '0;
         lcd_on_ff    <= 1'b0;
         vblank_ff    <= 1'b0;
         coin_irq_ff  <= 1'b0;
         tirq_ff      <= 1'b0;
         draw_ff      <= 1'b0;
         draw_line_ff <= '0;
         hblank_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_ph_ff    <= div_ph_in;
         div_val_ff   <= div_val_in;
         line_ph_ff   <= line_ph_in;
         line_ff      <= line_in;
         mode_ff      <= mode_in;
         coin_ff      <= coin_in;
         drawn_ff     <= drawn_in;
         tim_ph_ff    <= tim_ph_in;
         tim_val_ff   <= tim_val_in;
         tick_ff      <= tick_in;
         lcd_on_ff    <= lcd_on_in;
         vblank_ff    <= vblank_in;
         coin_irq_ff  <= coin_irq_in;
         tirq_ff      <= tirq_in;
         draw_ff      <= draw_in;
         draw_line_ff <= draw_line_in;
         hblank_ff    <= hblank_in;
      end
   end

   // result register, loaded when the step has settled
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_divider          <= div_val_ff;
         rsp_timer_count      <= tim_val_ff;
         rsp_line             <= line_ff;
         rsp_lcd_mode         <= mode_ff;
         rsp_coincidence      <= coin_ff;
         rsp_vblank_irq       <= vblank_ff;
         rsp_stat_irq         <= coin_irq_ff || stat_mode;
         rsp_timer_irq        <= tirq_ff;
         rsp_draw_request     <= draw_ff;
         rsp_draw_line_number <= draw_line_ff;
         rsp_line_end         <= hblank_ff;
      end
   end

`ifndef SYNTH
   a_no_pop_over_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !q_pop)
      else $error("queue popped while a result waits");

   a_line_phase_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUSY && line_pend) |=> (line_ph_ff < $past(line_ph_ff)))
      else $error("line phase did not drain");

   a_draw_visible: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_draw_request) |-> (rsp_draw_line_number < VBLANK_LINE))
      else $error("draw request outside visible lines");

   a_vblank_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_vblank_irq) |-> (rsp_lcd_mode == MODE_VBLANK && rsp_line_end))
      else $error("vblank raised without vblank mode and line end");
`endif

endmodule

/* src/handheld_timer_and_lcd_status.sv */
// Handheld timer and LCD status block. Each request transaction carries the number of
// machine cycles elapsed since the previous step; each one yields exactly one response
// transaction with DIV, TIMA, LY, STAT mode, the coincidence flag and the interrupt and
// draw pulses for that step. Steps are taken into a short queue by the front end and
// worked off one at a time by the back end: it pops a step and adds its cycles in, then
// works off the line ends (at most three) and the TIMA overflow runs in parallel, and
// then registers the result. A new step enters the back end in the same cycle the
// previous response is taken, if one is queued. The user must see that configuration
// is written through the csr port only while no transaction is in flight; the block
// itself does not enforce this.
module handheld_timer_and_lcd_status #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_write_enable,
   input  logic [htlcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [htlcd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_cycles,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_divider,
   output logic [7:0]                        rsp_timer_count,
   output logic [7:0]                        rsp_line,
   output logic [1:0]                        rsp_lcd_mode,
   output logic                              rsp_coincidence,
   output logic                              rsp_vblank_irq,
   output logic                              rsp_stat_irq,
   output logic                              rsp_timer_irq,
   output logic                              rsp_draw_request,
   output logic [7:0]                        rsp_draw_line_number,
   output logic                              rsp_line_end
);
   import htlcd_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   // register file: values masked to their width, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TIMER_ENABLE:      cfg_in.timer_enable      = csr_write_data[0];
            CSR_TIMER_RATE_SELECT: cfg_in.timer_rate_select = csr_write_data[1:0];
            CSR_TIMER_RELOAD:      cfg_in.timer_reload      = csr_write_data;
            CSR_LINE_COMPARE:      cfg_in.line_compare      = csr_write_data;
            CSR_STAT_IRQ_ENABLES:  cfg_in.stat_irq_enables  = csr_write_data[3:0];
            CSR_LCD_ENABLE:        cfg_in.lcd_enable        = csr_write_data[0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: accepts and classifies request transactions into the queue
   htlcd_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cycles (req_cycles),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // back end: divider, line sequencer and timer, plus the response register
   htlcd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .q_valid              (q_valid),
      .q_item               (q_item),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_divider          (rsp_divider),
      .rsp_timer_count      (rsp_timer_count),
      .rsp_line             (rsp_line),
      .rsp_lcd_mode         (rsp_lcd_mode),
      .rsp_coincidence      (rsp_coincidence),
      .rsp_vblank_irq       (rsp_vblank_irq),
      .rsp_stat_irq         (rsp_stat_irq),
      .rsp_timer_irq        (rsp_timer_irq),
      .rsp_draw_request     (rsp_draw_request),
      .rsp_draw_line_number (rsp_draw_line_number),
      .rsp_line_end         (rsp_line_end)
   );

endmodule

/* test/step_status_checker.sv */
`timescale 1ns / 100ps

module step_status_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [htlcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [htlcd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [7:0]                        req_cycles,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [7:0]                        rsp_divider,
   input  logic [7:0]                        rsp_timer_count,
   input  logic [7:0]                        rsp_line,
   input  logic [1:0]                        rsp_lcd_mode,
   input  logic                              rsp_coincidence,
   input  logic                              rsp_vblank_irq,
   input  logic                              rsp_stat_irq,
   input  logic                              rsp_timer_irq,
   input  logic                              rsp_draw_request,
   input  logic [7:0]                        rsp_draw_line_number,
   input  logic                              rsp_line_end,
   output int                                mismatch_count,
   output int                                outstanding
);
   import htlcd_pkg::*;

   typedef struct packed {
      logic [7:0] divider;
      logic [7:0] timer_count;
      logic [7:0] line;
      logic [1:0] lcd_mode;
      logic       coincidence;
      logic       vblank_irq;
      logic       stat_irq;
      logic       timer_irq;
      logic       draw_request;
      logic [7:0] draw_line_number;
      logic       line_end;
   } step_status_type;

   cfg_type         cfg;
   int unsigned     div_phase;
   int unsigned     line_phase;
   int unsigned     tick_phase;
   logic [7:0]      div_count;
   logic [7:0]      ly;
   logic [7:0]      tima;
   logic [1:0]      mode;
   logic            coinc_flag;
   logic            line_done;
   step_status_type pending_status[$];

   function automatic step_status_type advance_step(input logic [7:0] cyc);
      step_status_type s;
      int unsigned     period;
      s = '0;

      div_phase += cyc;
      while (div_phase >= 64) begin
         div_phase -= 64;
         div_count += 8'd1;
      end

      if (cfg.lcd_enable) begin
         line_phase += cyc;
         // mode picked from the line before any line end in this step
         if (ly >= VBLANK_LINE) begin
            mode = MODE_VBLANK;
         end else if (line_phase < OAM_START) begin
            mode      = MODE_HBLANK;
            line_done = 1'b0;
         end else if (line_phase < XFER_START) begin
            mode = MODE_OAM;
         end else begin
            mode = MODE_TRANSFER;
            if (!line_done) begin
               s.draw_request     = 1'b1;
               s.draw_line_number = ly;
               line_done          = 1'b1;
            end
         end

         while (line_phase >= LINE_PERIOD) begin
            line_phase -= LINE_PERIOD;
            s.line_end  = 1'b1;
            ly          = ly + 8'd1;
            if (ly > LAST_LINE) ly = 8'd0;
            if (ly == VBLANK_LINE) begin
               mode         = MODE_VBLANK;
               s.vblank_irq = 1'b1;
            end
            if (cfg.line_compare == ly) begin
               coinc_flag = 1'b1;
               if (cfg.stat_irq_enables[IRQ_EN_COINC]) s.stat_irq = 1'b1;
            end else begin
               coinc_flag = 1'b0;
            end
         end

         if (cfg.stat_irq_enables[IRQ_EN_OAM] && mode == MODE_OAM)
            s.stat_irq = 1'b1;
         else if (cfg.stat_irq_enables[IRQ_EN_VBLANK] && mode == MODE_VBLANK)
            s.stat_irq = 1'b1;
         else if (cfg.stat_irq_enables[IRQ_EN_HBLANK] && s.line_end)
            s.stat_irq = 1'b1;
      end

      if (cfg.timer_enable) begin
         // select 0 is the slowest rate and select 1 the fastest
         period = 1 << (2 * ((cfg.timer_rate_select == 2'd0) ? 4 : int'(cfg.timer_rate_select)));
         tick_phase += cyc;
         while (tick_phase >= period) begin
            tick_phase -= period;
            tima        = tima + 8'd1;
            if (tima == 8'd0) begin
               tima        = cfg.timer_reload;
               s.timer_irq = 1'b1;
            end
         end
      end

      s.divider     = div_count;
      s.timer_count = tima;
      s.line        = ly;
      s.lcd_mode    = mode;
      s.coincidence = coinc_flag;
      return s;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin : monitor
      step_status_type want;
      if (reset) begin
         cfg            = '0;
         div_phase      = 0;
         line_phase     = 0;
         tick_phase     = 0;
         div_count      = '0;
         ly             = '0;
         tima           = '0;
         mode           = MODE_HBLANK;
         coinc_flag     = 1'b0;
         line_done      = 1'b0;
         mismatch_count = 0;
         pending_status.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TIMER_ENABLE:      cfg.timer_enable      = csr_write_data[0];
               CSR_TIMER_RATE_SELECT: cfg.timer_rate_select = csr_write_data[1:0];
               CSR_TIMER_RELOAD:      cfg.timer_reload      = csr_write_data;
               CSR_LINE_COMPARE:      cfg.line_compare      = csr_write_data;
               CSR_STAT_IRQ_ENABLES:  cfg.stat_irq_enables  = csr_write_data[3:0];
               CSR_LCD_ENABLE:        cfg.lcd_enable        = csr_write_data[0];
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (pending_status.size() == 0) begin
               report_mismatch("response transaction with no step waiting");
            end else begin
               want = pending_status.pop_front();
               compare_field("divider", rsp_divider, want.divider);
               compare_field("timer_count", rsp_timer_count, want.timer_count);
               compare_field("line", rsp_line, want.line);
               compare_field("lcd_mode", 8'(rsp_lcd_mode), 8'(want.lcd_mode));
               compare_field("coincidence", 8'(rsp_coincidence), 8'(want.coincidence));
               compare_field("vblank_irq", 8'(rsp_vblank_irq), 8'(want.vblank_irq));
               compare_field("stat_irq", 8'(rsp_stat_irq), 8'(want.stat_irq));
               compare_field("timer_irq", 8'(rsp_timer_irq), 8'(want.timer_irq));
               compare_field("draw_request", 8'(rsp_draw_request), 8'(want.draw_request));
               compare_field("draw_line_number", rsp_draw_line_number,
                             want.draw_line_number);
               compare_field("line_end", 8'(rsp_line_end), 8'(want.line_end));
            end
         end

         if (req_valid && req_ready) pending_status.push_back(advance_step(req_cycles));
      end
      outstanding <= pending_status.size();
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import htlcd_pkg::*;

   // writes to these indexes must leave every register alone
   localparam logic [2:0]  CSR_UNUSED_LO = 3'd6;
   localparam logic [2:0]  CSR_UNUSED_HI = 3'd7;
   // generous ceiling on the whole run, in clock cycles
   localparam int unsigned RUN_LIMIT     = 400000;
   // long receiver hold-off used to back the block up
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned STEPS_PER_SET = 55;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_cycles       = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [7:0]             rsp_divider;
   logic [7:0]             rsp_timer_count;
   logic [7:0]             rsp_line;
   logic [1:0]             rsp_lcd_mode;
   logic                   rsp_coincidence;
   logic                   rsp_vblank_irq;
   logic                   rsp_stat_irq;
   logic                   rsp_timer_irq;
   logic                   rsp_draw_request;
   logic [7:0]             rsp_draw_line_number;
   logic                   rsp_line_end;

   int                     mismatch_count;
   int                     outstanding;

   // idle rates in percent per cycle, set by the stimulus
   int unsigned            tx_idle_pct = 0;
   int unsigned            rx_idle_pct = 0;
   bit                     hold_go     = 1'b0;
   logic                   rsp_hold    = 1'b0;
   int unsigned            cycle_count = 0;

   handheld_timer_and_lcd_status DUT (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cycles           (req_cycles),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_divider          (rsp_divider),
      .rsp_timer_count      (rsp_timer_count),
      .rsp_line             (rsp_line),
      .rsp_lcd_mode         (rsp_lcd_mode),
      .rsp_coincidence      (rsp_coincidence),
      .rsp_vblank_irq       (rsp_vblank_irq),
      .rsp_stat_irq         (rsp_stat_irq),
      .rsp_timer_irq        (rsp_timer_irq),
      .rsp_draw_request     (rsp_draw_request),
      .rsp_draw_line_number (rsp_draw_line_number),
      .rsp_line_end         (rsp_line_end)
   );

   step_status_checker status_check (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cycles           (req_cycles),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_divider          (rsp_divider),
      .rsp_timer_count      (rsp_timer_count),
      .rsp_line             (rsp_line),
      .rsp_lcd_mode         (rsp_lcd_mode),
      .rsp_coincidence      (rsp_coincidence),
      .rsp_vblank_irq       (rsp_vblank_irq),
      .rsp_stat_irq         (rsp_stat_irq),
      .rsp_timer_irq        (rsp_timer_irq),
      .rsp_draw_request     (rsp_draw_request),
      .rsp_draw_line_number (rsp_draw_line_number),
      .rsp_line_end         (rsp_line_end),
      .mismatch_count       (mismatch_count),
      .outstanding          (outstanding)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run ceiling, in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stalls, forced low during the long hold-off
   always @(posedge clock) begin
      if (reset || rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // long hold-off, counted here so the sender keeps going meanwhile
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // offer one step transaction and wait for it to be taken; valid stays high
   // into the next transaction unless the sender decides to idle first
   task automatic send_step(input logic [7:0] cyc);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cycles <= cyc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop offering and wait until every response has been taken
   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // all registers rewritten while idle; spare upper bits carry junk so the
   // masking is exercised, and one unused index is hit each time
   task automatic apply_settings(input logic te, input logic [1:0] rs,
                                 input logic [7:0] tma, input logic [7:0] lyc,
                                 input logic [3:0] en, input logic lcd);
      logic [7:0] junk;
      drain_all();
      junk = 8'($urandom);
      write_csr(CSR_TIMER_ENABLE, {junk[7:1], te});
      junk = 8'($urandom);
      write_csr(CSR_TIMER_RATE_SELECT, {junk[7:2], rs});
      write_csr(CSR_TIMER_RELOAD, tma);
      write_csr(CSR_LINE_COMPARE, lyc);
      junk = 8'($urandom);
      write_csr(CSR_STAT_IRQ_ENABLES, {junk[7:4], en});
      write_csr(($urandom_range(0, 1) == 0) ? CSR_UNUSED_LO : CSR_UNUSED_HI,
                8'($urandom));
      junk = 8'($urandom);
      write_csr(CSR_LCD_ENABLE, {junk[7:1], lcd});
      csr_write_enable <= 1'b0;
   endtask

   // short instruction-sized steps and full-range steps in equal share, some long ones
   function automatic logic [7:0] random_cycles();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return 8'($urandom_range(0, 24));
      if (pick < 8) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(100, 255));
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: lcd off and timer off, so only the divider moves
      send_step(8'd255);
      send_step(8'd0);

      // fastest timer with reload at the top, every stat interrupt enabled;
      // walk the line phase across the oam, transfer and line-end boundaries
      apply_settings(1'b1, 2'd1, 8'd255, 8'd0, 4'hF, 1'b1);
      send_step(8'd0);
      send_step(8'd50);
      send_step(8'd1);
      send_step(8'd20);
      send_step(8'd10);
      send_step(8'd42);
      send_step(8'd113);
      send_step(8'd114);
      send_step(8'd255);

      // slowest rate builds up timer phase, coincidence interrupt only
      apply_settings(1'b1, 2'd0, 8'd254, 8'd1, 4'b1000, 1'b1);
      send_step(8'd255);
      send_step(8'd255);

      // switch to the fastest rate: the kept phase drains in one step
      apply_settings(1'b1, 2'd1, 8'd255, 8'd255, 4'b0001, 1'b1);
      send_step(8'd0);
      send_step(8'd70);

      // lcd off and timer off mid-frame: line, mode and tima hold
      apply_settings(1'b0, 2'd2, 8'd128, 8'd3, 4'b0110, 1'b0);
      send_step(8'd200);
      send_step(8'd255);

      // lcd back on with lyc at the vblank line
      apply_settings(1'b1, 2'd2, 8'd0, 8'd144, 4'hF, 1'b1);
      send_step(8'd255);
      send_step(8'd255);
      send_step(8'd255);

      // random part: receiver idle heavy, then sender idle heavy, then none
      for (int idle_sel = 0; idle_sel < 3; idle_sel++) begin
         case (idle_sel)
            0: begin
               tx_idle_pct = 20;
               rx_idle_pct = 84;
            end
            1: begin
               tx_idle_pct = 84;
               rx_idle_pct = 20;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (int set_sel = 0; set_sel < 3; set_sel++) begin
            case ((idle_sel * 3 + set_sel) % 4)
               0: apply_settings(1'b1, 2'd3, 8'd255, 8'd153, 4'hF, 1'b1);
               1: apply_settings(1'b1, 2'd0, 8'd0, 8'd144, 4'($urandom), 1'b1);
               2: apply_settings(1'($urandom), 2'($urandom), 8'($urandom),
                                 8'($urandom_range(0, 153)), 4'($urandom), 1'b1);
               default: apply_settings(1'b1, 2'd1, 8'($urandom), 8'd255,
                                       4'($urandom), 1'b0);
            endcase
            // back the block up while the sender keeps offering
            if (idle_sel == 2 && set_sel == 1) hold_go = 1'b1;
            repeat (STEPS_PER_SET) send_step(random_cycles());
         end
      end

      // let the last responses arrive and watch for strays
      drain_all();
      repeat (200) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
